[hw/rtl/tpc_pkg.sv]
// tree pseudo-lru cache set: shared sizes, mode codes and internal control types
// no dependencies
`timescale 1ns / 1ps

package tpc_pkg;

  localparam int unsigned Ways    = 8;
  localparam int unsigned TagBits = 20;
  localparam int unsigned WayBits = $clog2(Ways);

  typedef enum logic [1:0] {
    ModeLookup  = 2'd0,
    ModeFill    = 2'd1,
    ModeReplace = 2'd2
  } mode_e;

  // plru tree request: touch the path of a way, or walk and flip for replace
  typedef struct packed {
    logic               touch;
    logic               replace;
    logic [WayBits-1:0] way;
  } plru_ctrl_t;

  // tag store write port
  typedef struct packed {
    logic               en;
    logic [WayBits-1:0] way;
    logic [TagBits-1:0] tag;
  } store_wr_t;

  // tag store match and free-way status
  typedef struct packed {
    logic               hit;
    logic [WayBits-1:0] hit_way;
    logic               has_empty;
    logic [WayBits-1:0] empty_way;
  } store_stat_t;

endpackage

[hw/rtl/tpc_in_if.sv]
// request channel of the cache set: valid/ready plus mode and tag
// depends on tpc_pkg
`timescale 1ns / 1ps

interface tpc_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [tpc_pkg::TagBits-1:0] tag;

  modport source (output valid, output mode, output tag, input ready);
  modport sink (input valid, input mode, input tag, output ready);
endinterface

[hw/rtl/tpc_out_if.sv]
// response channel of the cache set: valid/ready plus status and victim line
// depends on tpc_pkg
`timescale 1ns / 1ps

interface tpc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [tpc_pkg::TagBits-1:0] victim_tag;
  logic                        victim_valid;

  modport source (output valid, output status, output victim_tag, output victim_valid,
                  input ready);
  modport sink (input valid, input status, input victim_tag, input victim_valid,
                output ready);
endinterface

[hw/rtl/tpc_plru.sv]
// pseudo-lru tree bits: victim walk with flip, and path update on hit or fill
// depends on tpc_pkg
`timescale 1ns / 1ps

module tpc_plru (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tpc_pkg::plru_ctrl_t          ctrl_i,
  output logic [tpc_pkg::WayBits-1:0]  repl_way_o
);

  // node n has children 2n and 2n+1, root is node 1
  logic [tpc_pkg::Ways-1:1] plru_q, plru_d;

  always_comb begin
    logic [tpc_pkg::WayBits:0] wnode;
    logic [tpc_pkg::WayBits:0] leaf;
    logic                      b;
    plru_d = plru_q;
    wnode  = (tpc_pkg::WayBits+1)'(1);
    for (int k = 0; k < tpc_pkg::WayBits; k++) begin
      b = plru_q[wnode[tpc_pkg::WayBits-1:0]];
      if (ctrl_i.replace) begin
        plru_d[wnode[tpc_pkg::WayBits-1:0]] = ~b;
      end
      wnode = {wnode[tpc_pkg::WayBits-1:0], b};
    end
    repl_way_o = wnode[tpc_pkg::WayBits-1:0];

    // walk leaf to root: parent gets 0 when we came from its right child
    leaf = {1'b1, ctrl_i.way};
    for (int k = 0; k < tpc_pkg::WayBits; k++) begin
      if (ctrl_i.touch) begin
        plru_d[leaf[tpc_pkg::WayBits:1]] = ~leaf[0];
      end
      leaf = leaf >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plru_q <= '0;
    end else begin
      plru_q <= plru_d;
    end
  end

endmodule

[hw/rtl/tpc_store.sv]
// tag and valid storage of the ways, parallel compare and free-way search
// depends on tpc_pkg
`timescale 1ns / 1ps

module tpc_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tpc_pkg::TagBits-1:0]  cmp_tag_i,
  input  logic [tpc_pkg::WayBits-1:0]  rd_way_i,
  input  tpc_pkg::store_wr_t           wr_i,
  output tpc_pkg::store_stat_t         stat_o,
  output logic [tpc_pkg::TagBits-1:0]  rd_tag_o,
  output logic                         rd_valid_o
);

  logic [tpc_pkg::TagBits-1:0] tags_q [tpc_pkg::Ways];
  logic [tpc_pkg::Ways-1:0]    valid_q;

  // highest-numbered way wins in both searches
  always_comb begin
    stat_o = '0;
    for (int w = 0; w < tpc_pkg::Ways; w++) begin
      if (valid_q[w] && (tags_q[w] == cmp_tag_i)) begin
        stat_o.hit     = 1'b1;
        stat_o.hit_way = tpc_pkg::WayBits'(w);
      end
      if (!valid_q[w]) begin
        stat_o.has_empty = 1'b1;
        stat_o.empty_way = tpc_pkg::WayBits'(w);
      end
    end
  end

  // an empty way reads as zero so unwritten tags never leak out
  assign rd_valid_o = valid_q[rd_way_i];
  assign rd_tag_o   = valid_q[rd_way_i] ? tags_q[rd_way_i] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.way] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      tags_q[wr_i.way] <= wr_i.tag;
    end
  end

endmodule

[hw/rtl/tree_plru_cache_set.sv]
// One cache set of tpc_pkg::Ways ways with a tree pseudo-LRU policy. A request
// (lookup, fill of an empty way, or pseudo-LRU replace) is registered, resolved
// against the tags, valid bits and tree bits, and its response lands in an output
// register; one request is taken per cycle while the response side is not stalled.
// The set state is updated at the moment the response is registered, so
// back-to-back requests see each other's effects. A stalled response holds the
// request stage, and in_i.ready follows out_o.ready combinationally. Tag and
// valid storage leaves reset empty at once.
// depends on tpc_pkg, tpc_in_if, tpc_out_if, tpc_plru, tpc_store
`timescale 1ns / 1ps

module tree_plru_cache_set (
  input  logic  clk_i,
  input  logic  rst_ni,
  tpc_in_if.sink    in_i,
  tpc_out_if.source out_o
);

  logic                        in_valid_q;
  logic [1:0]                  mode_q;
  logic [tpc_pkg::TagBits-1:0] tag_q;

  logic                        out_valid_q;
  logic                        status_q, status_d;
  logic [tpc_pkg::TagBits-1:0] vtag_q, vtag_d;
  logic                        vvalid_q, vvalid_d;

  logic                        advance;
  tpc_pkg::plru_ctrl_t         plru_ctrl;
  logic [tpc_pkg::WayBits-1:0] repl_way;
  tpc_pkg::store_wr_t          store_wr;
  tpc_pkg::store_stat_t        store_stat;
  logic [tpc_pkg::TagBits-1:0] rd_tag;
  logic                        rd_valid;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  tpc_plru u_plru (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (plru_ctrl),
    .repl_way_o (repl_way)
  );

  tpc_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmp_tag_i  (tag_q),
    .rd_way_i   (repl_way),
    .wr_i       (store_wr),
    .stat_o     (store_stat),
    .rd_tag_o   (rd_tag),
    .rd_valid_o (rd_valid)
  );

  always_comb begin
    plru_ctrl = '0;
    store_wr  = '0;
    store_wr.tag = tag_q;
    status_d  = 1'b1;
    vtag_d    = '0;
    vvalid_d  = 1'b0;
    case (tpc_pkg::mode_e'(mode_q))
      tpc_pkg::ModeLookup: begin
        status_d        = !store_stat.hit;
        plru_ctrl.touch = advance && store_stat.hit;
        plru_ctrl.way   = store_stat.hit_way;
      end
      tpc_pkg::ModeFill: begin
        status_d        = !store_stat.has_empty;
        plru_ctrl.touch = advance && store_stat.has_empty;
        plru_ctrl.way   = store_stat.empty_way;
        store_wr.en     = advance && store_stat.has_empty;
        store_wr.way    = store_stat.empty_way;
      end
      tpc_pkg::ModeReplace: begin
        status_d          = 1'b0;
        vtag_d            = rd_tag;
        vvalid_d          = rd_valid;
        plru_ctrl.replace = advance;
        store_wr.en       = advance;
        store_wr.way      = repl_way;
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q <= in_i.mode;
      tag_q  <= in_i.tag;
    end
    if (advance) begin
      status_q <= status_d;
      vtag_q   <= vtag_d;
      vvalid_q <= vvalid_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.victim_tag   = vtag_q;
  assign out_o.victim_valid = vvalid_q;

  // an eviction only comes from replace, which always succeeds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && vvalid_q |-> !status_q)
    else $error("victim reported with failing status");

  // victim tag is zero unless a valid line was evicted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !vvalid_q |-> vtag_q == '0)
    else $error("victim tag nonzero without evicted line");

  // a pending request is never dropped while the response side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(mode_q) && $stable(tag_q))
    else $error("stalled request lost");

  // a replace that advances shows up as a successful response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (mode_q == tpc_pkg::ModeReplace) |=> out_valid_q && !status_q)
    else $error("replace response missing or failing");

endmodule
